[rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted (active low)
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion, checked at every edge including reset
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/grbq_pkg.sv]
// package for the generation ring broadcast queue: constants and helpers
package grbq_pkg;

    localparam int MAX_DEPTH_DEF     = 16;
    localparam int MESSAGE_WIDTH_DEF = 64;

    localparam int GEN_W   = 32;
    localparam int REQ_W   = 5;
    localparam int LOG_W   = 4;

    localparam logic CMD_PUBLISH = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [REQ_W-1:0] REQ_DEPTH_RESET = 5'd1;

    // log2 of the largest power of two not above max_depth
    function automatic int cap_log(input int max_depth);
        int lg;
        lg = 0;
        while ((2 << lg) <= max_depth) begin
            lg = lg + 1;
        end
        return lg;
    endfunction

    // log2 of the requested depth rounded up to a power of two, 0 and 1 give 0
    function automatic logic [LOG_W-1:0] req_log(input logic [REQ_W-1:0] req);
        logic [LOG_W-1:0] lg;
        lg = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if ((32'd1 << i) < 32'(req)) begin
                lg = LOG_W'(i + 1);
            end
        end
        return lg;
    endfunction

endpackage

[rtl/grbq_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module grbq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/generation_ring_broadcast_queue_unit.sv]
// generation ring broadcast queue: top level with input, ram and result stages
// path: each input transfer is registered in the input, middle and result stages in turn
// throughput: one item per cycle unless stalled; each item needs one ring ram access
// reset: synchronous active-low aresetn clears valids, write generation,
// written-slot count, active flag and sets the requested depth to 1; no clearing pass
module generation_ring_broadcast_queue_unit
    #(
    parameter int MAX_DEPTH     = grbq_pkg::MAX_DEPTH_DEF,
    parameter int MESSAGE_WIDTH = grbq_pkg::MESSAGE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [grbq_pkg::REQ_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [MESSAGE_WIDTH-1:0]       s_message_in,
    input  logic [grbq_pkg::GEN_W-1:0]     s_reader_generation,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [MESSAGE_WIDTH-1:0]       m_message_out,
    output logic [grbq_pkg::GEN_W-1:0]     m_next_generation,
    output logic [grbq_pkg::GEN_W-1:0]     m_pending_updates,
    output logic [grbq_pkg::GEN_W-1:0]     m_start_generation
);

    import grbq_pkg::*;

    localparam int CAP_LOG = cap_log(MAX_DEPTH);
    localparam int CAP     = 1 << CAP_LOG;
    localparam int ADDR_W  = CAP > 1 ? $clog2(CAP) : 1;
    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);

    logic                   en;

    logic [REQ_W-1:0]       req_depth_reg;

    logic                   in_valid_reg;
    logic                   in_cmd_reg;
    logic [MESSAGE_WIDTH-1:0] in_msg_reg;
    logic [GEN_W-1:0]       in_gen_reg;

    logic [GEN_W-1:0]       wgen_reg, wgen_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   active_reg, active_next;

    logic                   mid_valid_reg;
    logic                   mid_use_ram_reg, mid_use_ram_next;
    logic                   mid_ok_reg, mid_ok_next;
    logic [GEN_W-1:0]       mid_next_gen_reg, mid_next_gen_next;
    logic [GEN_W-1:0]       mid_pending_reg, mid_pending_next;
    logic [GEN_W-1:0]       mid_start_reg, mid_start_next;

    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic [MESSAGE_WIDTH-1:0] out_msg_reg;
    logic [GEN_W-1:0]       out_next_gen_reg;
    logic [GEN_W-1:0]       out_pending_reg;
    logic [GEN_W-1:0]       out_start_reg;

    logic [LOG_W-1:0]       depth_log;
    logic [CNT_W-1:0]       depth;
    logic [GEN_W-1:0]       mask32;
    logic [GEN_W-1:0]       depth32;
    logic [ADDR_W-1:0]      wr_slot;
    logic [ADDR_W-1:0]      rd_slot;
    logic [GEN_W-1:0]       lag;
    logic [GEN_W-1:0]       adj_gen;
    logic                   hit;
    logic                   publish;
    logic [MESSAGE_WIDTH-1:0] ram_rd_data;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;
    assign publish = en && in_valid_reg && (in_cmd_reg == CMD_PUBLISH);

    // depth rounding and capping
    always_comb begin
        depth_log = req_log(req_depth_reg);
        if (32'(depth_log) > CAP_LOG) begin
            depth_log = LOG_W'(CAP_LOG);
        end
        depth   = CNT_W'(1) << depth_log;
        depth32 = GEN_W'(depth);
        mask32  = depth32 - GEN_W'(1);
    end

    // slot selection and reader adjustment
    always_comb begin
        wr_slot = ADDR_W'(wgen_reg & mask32);
        lag     = wgen_reg - in_gen_reg;
        priority if (lag == '0) begin
            adj_gen = wgen_reg - GEN_W'(1);
        end else if (lag > depth32) begin
            adj_gen = wgen_reg - depth32;
        end else begin
            adj_gen = in_gen_reg;
        end
        rd_slot = ADDR_W'(adj_gen & mask32);
        hit     = active_reg && (CNT_W'(rd_slot) < count_reg);
    end

    // state update and stage results
    always_comb begin
        wgen_next         = wgen_reg;
        count_next        = count_reg;
        active_next       = active_reg;
        mid_use_ram_next  = 1'b0;
        mid_ok_next       = 1'b0;
        mid_next_gen_next = in_gen_reg;
        if (in_cmd_reg == CMD_PUBLISH) begin
            wgen_next         = wgen_reg + GEN_W'(1);
            active_next       = 1'b1;
            if ((CNT_W'(wr_slot) >= count_reg) && (count_reg < depth)) begin
                count_next = count_reg + CNT_W'(1);
            end
            mid_ok_next       = 1'b1;
            mid_next_gen_next = wgen_next;
        end else if (active_reg) begin
            mid_ok_next       = hit;
            mid_use_ram_next  = hit;
            mid_next_gen_next = hit ? adj_gen + GEN_W'(1) : adj_gen;
        end
        mid_pending_next = wgen_next - in_gen_reg;
        mid_start_next   = wgen_next - GEN_W'(active_next);
    end

    grbq_ram #(
        .WIDTH (MESSAGE_WIDTH),
        .DEPTH (CAP)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (publish),
        .wr_addr (wr_slot),
        .wr_data (in_msg_reg),
        .rd_en   (en),
        .rd_addr (rd_slot),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_depth_reg <= REQ_DEPTH_RESET;
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            wgen_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                req_depth_reg <= cfg_wr_data;
            end
            if (en) begin
                in_valid_reg  <= s_valid;
                mid_valid_reg <= in_valid_reg;
                out_valid_reg <= mid_valid_reg;
            end
            if (publish) begin
                wgen_reg   <= wgen_next;
                count_reg  <= count_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_cmd_reg       <= s_command;
            in_msg_reg       <= s_message_in;
            in_gen_reg       <= s_reader_generation;
            mid_use_ram_reg  <= mid_use_ram_next;
            mid_ok_reg       <= mid_ok_next;
            mid_next_gen_reg <= mid_next_gen_next;
            mid_pending_reg  <= mid_pending_next;
            mid_start_reg    <= mid_start_next;
            out_ok_reg       <= mid_ok_reg;
            out_msg_reg      <= mid_use_ram_reg ? ram_rd_data : '0;
            out_next_gen_reg <= mid_next_gen_reg;
            out_pending_reg  <= mid_pending_reg;
            out_start_reg    <= mid_start_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_ok               = out_ok_reg;
    assign m_message_out      = out_msg_reg;
    assign m_next_generation  = out_next_gen_reg;
    assign m_pending_updates  = out_pending_reg;
    assign m_start_generation = out_start_reg;

endmodule

[rtl/grbq_checker.sv]
// port-level checker for the generation ring broadcast queue, with its bind
`include "assert_macros.svh"

module grbq_checker #(
    parameter int MESSAGE_WIDTH = grbq_pkg::MESSAGE_WIDTH_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_wr_en,
    input logic [grbq_pkg::REQ_W-1:0] cfg_wr_data,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_command,
    input logic [MESSAGE_WIDTH-1:0]   s_message_in,
    input logic [grbq_pkg::GEN_W-1:0] s_reader_generation,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_ok,
    input logic [MESSAGE_WIDTH-1:0]   m_message_out,
    input logic [grbq_pkg::GEN_W-1:0] m_next_generation,
    input logic [grbq_pkg::GEN_W-1:0] m_pending_updates,
    input logic [grbq_pkg::GEN_W-1:0] m_start_generation
);

    // failed reads carry no message
    `ASSERT_CLK_RST(a_fail_zero_msg, aclk, aresetn, (m_valid && !m_ok) |-> (m_message_out == '0), "failed result with nonzero message")

    // no result right after reset
    `ASSERT_CLK(a_reset_no_result, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    // input side never blocked while the result side drains
    `ASSERT_CLK_RST(a_ready_follows, aclk, aresetn, (m_ready || !m_valid) |-> s_ready, "input stalled with free result stage")

    // stalled result holds
    `ASSERT_CLK_RST(a_result_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) && $stable(m_message_out) && $stable(m_next_generation)), "stalled result changed")

endmodule

bind generation_ring_broadcast_queue_unit grbq_checker #(
    .MESSAGE_WIDTH (MESSAGE_WIDTH)
) u_grbq_checker (.*);

[verif/testbench.sv]
// testbench for the generation ring broadcast queue: planned publish and read traffic checked by a ring model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grbq_pkg::*;

    localparam int DEPTH_MAX   = MAX_DEPTH_DEF;
    localparam int MSG_W       = MESSAGE_WIDTH_DEF;
    localparam int SLOT_W      = DEPTH_MAX > 1 ? $clog2(DEPTH_MAX) : 1;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 85;

    typedef struct packed {
        logic             command;
        logic [MSG_W-1:0] message;
        logic [GEN_W-1:0] reader_gen;
    } request_t;

    typedef struct packed {
        logic             ok;
        logic [MSG_W-1:0] message;
        logic [GEN_W-1:0] next_gen;
        logic [GEN_W-1:0] pending;
        logic [GEN_W-1:0] start_gen;
    } reply_t;

    typedef struct packed {
        logic [REQ_W-1:0]                req_depth;
        logic [GEN_W-1:0]                write_gen;
        logic [DEPTH_MAX-1:0][MSG_W-1:0] slots;
        logic [DEPTH_MAX-1:0]            filled;
        logic [GEN_W-1:0]                counted;
        logic                            active;
    } ring_t;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REQ_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_PUBLISH;
    logic [MSG_W-1:0]     s_message_in = '0;
    logic [GEN_W-1:0]     s_reader_generation = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_ok;
    logic [MSG_W-1:0]     m_message_out;
    logic [GEN_W-1:0]     m_next_generation;
    logic [GEN_W-1:0]     m_pending_updates;
    logic [GEN_W-1:0]     m_start_generation;

    request_t    queued_requests[$];
    reply_t      awaited_replies[$];
    request_t    in_flight;
    ring_t       ring_now;
    ring_t       ring_plan;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_tick = 0;
    int          idle_cycles = 0;

    generation_ring_broadcast_queue_unit uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_message_in        (s_message_in),
        .s_reader_generation (s_reader_generation),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ok                (m_ok),
        .m_message_out       (m_message_out),
        .m_next_generation   (m_next_generation),
        .m_pending_updates   (m_pending_updates),
        .m_start_generation  (m_start_generation)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [GEN_W-1:0] ring_depth(input logic [REQ_W-1:0] req);
        logic [GEN_W-1:0] d;
        logic [GEN_W-1:0] cap;
        d = 1;
        cap = 1;
        while (cap * 2 <= DEPTH_MAX) cap = cap * 2;
        while (d < req) d = d * 2;
        if (d > cap) d = cap;
        return d;
    endfunction

    // blank is set when a read lands on a counted slot that was never written
    function automatic reply_t broadcast_step(input ring_t cur, input request_t q,
                                              output ring_t nxt, output bit blank);
        logic [GEN_W-1:0]  depth;
        logic [GEN_W-1:0]  g;
        logic [SLOT_W-1:0] slot;
        reply_t r;
        nxt = cur;
        blank = 1'b0;
        r = '0;
        depth = ring_depth(cur.req_depth);
        if (q.command == CMD_PUBLISH) begin
            slot = SLOT_W'(nxt.write_gen & (depth - 1));
            nxt.active = 1'b1;
            nxt.slots[slot] = q.message;
            nxt.filled[slot] = 1'b1;
            if (GEN_W'(slot) >= nxt.counted && nxt.counted < depth) begin
                nxt.counted = nxt.counted + 1;
            end
            nxt.write_gen = nxt.write_gen + 1;
            r.next_gen = nxt.write_gen;
            r.ok = 1'b1;
        end else if (!nxt.active) begin
            r.next_gen = q.reader_gen;
        end else begin
            g = q.reader_gen;
            if (nxt.write_gen == g) begin
                g = nxt.write_gen - 1;
            end else if (nxt.write_gen - g > depth) begin
                g = nxt.write_gen - depth;
            end
            slot = SLOT_W'(g & (depth - 1));
            if (GEN_W'(slot) < nxt.counted) begin
                blank = !nxt.filled[slot];
                r.message = nxt.slots[slot];
                r.ok = 1'b1;
                g = g + 1;
            end
            r.next_gen = g;
        end
        r.pending = nxt.write_gen - q.reader_gen;
        r.start_gen = nxt.write_gen - GEN_W'(nxt.active);
        return r;
    endfunction

    function automatic logic [MSG_W-1:0] random_message();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return MSG_W'(1) << $urandom_range(0, MSG_W - 1);
            default: return MSG_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [MSG_W-1:0] got,
                                   input logic [MSG_W-1:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic plan_request(input logic cmd, input logic [MSG_W-1:0] msg,
                                input logic [GEN_W-1:0] rgen,
                                output logic [GEN_W-1:0] next_gen);
        request_t q;
        reply_t r;
        ring_t nxt;
        bit blank;
        q.command = cmd;
        q.message = msg;
        q.reader_gen = rgen;
        r = broadcast_step(ring_plan, q, nxt, blank);
        if (blank) begin
            q.reader_gen = ring_plan.write_gen;
            r = broadcast_step(ring_plan, q, nxt, blank);
        end
        if (blank) begin
            q.command = CMD_PUBLISH;
            r = broadcast_step(ring_plan, q, nxt, blank);
        end
        ring_plan = nxt;
        next_gen = r.next_gen;
        queued_requests.push_back(q);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (queued_requests.size() != 0 || s_valid || awaited_replies.size() != 0);
    endtask

    task automatic write_depth(input logic [REQ_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ring_now.req_depth = value;
        ring_plan.req_depth = value;
    endtask

    always @(posedge aclk) begin : request_drive
        reply_t r;
        ring_t nxt;
        bit blank;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                r = broadcast_step(ring_now, in_flight, nxt, blank);
                ring_now = nxt;
                awaited_replies.push_back(r);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    in_flight = queued_requests.pop_front();
                    s_valid <= 1'b1;
                    s_command <= in_flight.command;
                    s_message_in <= in_flight.message;
                    s_reader_generation <= in_flight.reader_gen;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                    default: m_ready <= ((rx_tick % 9) < 5);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("transfer with nothing awaited", MSG_W'(m_next_generation), '0);
            end else begin
                want = awaited_replies.pop_front();
                if (m_ok !== want.ok) report_mismatch("ok", MSG_W'(m_ok), MSG_W'(want.ok));
                if (m_message_out !== want.message) begin
                    report_mismatch("message_out", m_message_out, want.message);
                end
                if (m_next_generation !== want.next_gen) begin
                    report_mismatch("next_generation", MSG_W'(m_next_generation),
                                    MSG_W'(want.next_gen));
                end
                if (m_pending_updates !== want.pending) begin
                    report_mismatch("pending_updates", MSG_W'(m_pending_updates),
                                    MSG_W'(want.pending));
                end
                if (m_start_generation !== want.start_gen) begin
                    report_mismatch("start_generation", MSG_W'(m_start_generation),
                                    MSG_W'(want.start_gen));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [GEN_W-1:0] nx;
        logic [GEN_W-1:0] rg;
        logic [GEN_W-1:0] depth;
        logic [GEN_W-1:0] readers [4];
        int depth_list [PHASES];
        int pick;
        int k;
        bit chained;
        ring_now = '0;
        ring_now.req_depth = REQ_DEPTH_RESET;
        ring_plan = ring_now;
        for (int i = 0; i < 4; i++) readers[i] = '0;
        depth_list = '{0, 2, 4, 16, 1, 3, 8, 5, 12, 16, 0};
        depth_list[PHASES - 1] = $urandom_range(0, 16);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_depth(REQ_W'(16));

        // reads with nothing published, then a small ring at depth 16
        plan_request(CMD_READ, '0, '0, nx);
        plan_request(CMD_READ, '1, '1, nx);
        plan_request(CMD_PUBLISH, '0, '0, nx);
        plan_request(CMD_PUBLISH, '1, '1, nx);
        plan_request(CMD_PUBLISH, {16{4'hA}}, 32'h5a5a_5a5a, nx);
        plan_request(CMD_READ, '0, ring_plan.write_gen, nx);
        plan_request(CMD_READ, '0, '0, nx);
        plan_request(CMD_READ, '0, '1, nx);
        plan_request(CMD_READ, '0, ring_plan.write_gen - 16, nx);
        plan_request(CMD_READ, '0, 32'h8000_0000, nx);
        plan_request(CMD_READ, '0, ring_plan.write_gen + 1, nx);
        plan_request(CMD_PUBLISH, {1'b1, {(MSG_W - 1){1'b0}}}, '0, nx);
        plan_request(CMD_PUBLISH, {16{4'h5}}, '0, nx);
        plan_request(CMD_READ, '0, 32'd1, nx);
        plan_request(CMD_READ, '0, ring_plan.write_gen - 17, nx);
        plan_request(CMD_READ, '1, 32'h7fff_ffff, nx);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_depth(REQ_W'(depth_list[p]));
            ready_mode <= ready_mode_t'(p % 3);
            if (p == 2) hold_seq <= hold_seq + 1;
            depth = ring_depth(ring_plan.req_depth);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 45) begin
                    plan_request(CMD_PUBLISH, random_message(), $urandom, nx);
                end else begin
                    k = $urandom_range(0, 3);
                    pick = $urandom_range(0, 99);
                    chained = 1'b0;
                    if (pick < 55) begin
                        rg = readers[k];
                        chained = 1'b1;
                    end else if (pick < 63) begin
                        rg = ring_plan.write_gen - GEN_W'(ring_plan.active);
                        chained = 1'b1;
                    end else if (pick < 75) begin
                        rg = ring_plan.write_gen - $urandom_range(0, depth + 1);
                    end else if (pick < 83) begin
                        rg = ring_plan.write_gen - $urandom_range(depth + 1, 5000);
                    end else if (pick < 90) begin
                        rg = ring_plan.write_gen + $urandom_range(1, 50);
                    end else begin
                        rg = $urandom;
                    end
                    plan_request(CMD_READ, random_message(), rg, nx);
                    if (chained) readers[k] = nx;
                end
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
